// ===== sv/grid_maze_path_finder_defines.svh =====
// Assertion macros shared by the maze path finder RTL.
// Depends on nothing; expects i_clk and i_rst_n in the including module.
`ifndef GRID_MAZE_PATH_FINDER_DEFINES_SVH
`define GRID_MAZE_PATH_FINDER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GMP_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/gmp_pkg.sv =====
// Shared types, constants and helper functions of the maze path finder.
// Depends on nothing; used by every module of the block except gmp_ram.
package gmp_pkg;

    localparam int ROWS      = 8;
    localparam int COLS      = 8;
    localparam int CELLS     = ROWS * COLS;
    localparam int INTERIOR  = (ROWS - 2) * (COLS - 2);
    localparam int CELL_AW   = $clog2(CELLS);
    localparam int STK_AW    = $clog2(INTERIOR);
    localparam int DEPTH_W   = $clog2(INTERIOR + 1);
    localparam int COORD_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int DIR_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_START_ROW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_START_COL = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_END_ROW   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_END_COL   = CFG_IDX_W'(3);

    localparam logic [DIR_W-1:0] DIR_UP    = DIR_W'(0);
    localparam logic [DIR_W-1:0] DIR_DOWN  = DIR_W'(1);
    localparam logic [DIR_W-1:0] DIR_LEFT  = DIR_W'(2);
    localparam logic [DIR_W-1:0] DIR_RIGHT = DIR_W'(3);
    localparam logic [DIR_W-1:0] DIR_DONE  = DIR_W'(4);

    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic               cell_open;
    } t_in;

    typedef struct packed {
        logic [COORD_W-1:0] path_row;
        logic [COORD_W-1:0] path_col;
        logic               found;
        logic               last;
    } t_out;

    typedef struct packed {
        logic [COORD_W-1:0] start_row;
        logic [COORD_W-1:0] start_col;
        logic [COORD_W-1:0] end_row;
        logic [COORD_W-1:0] end_col;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [DIR_W-1:0]   dir;
    } t_stk_entry;

    localparam int STK_W = $bits(t_stk_entry);

    typedef struct packed {
        logic               we;
        logic [CELL_AW-1:0] waddr;
        logic               wdata;
        logic               re;
        logic [CELL_AW-1:0] raddr;
    } t_bit_req;

    typedef struct packed {
        logic              we;
        logic [STK_AW-1:0] waddr;
        t_stk_entry        wdata;
        logic              re;
        logic [STK_AW-1:0] raddr;
    } t_stk_req;

    typedef struct packed {
        logic load;
        t_out data;
    } t_emit;

    function automatic logic in_grid(input logic [COORD_W-1:0] row,
                                     input logic [COORD_W-1:0] col);
        return (int'(row) < ROWS) && (int'(col) < COLS);
    endfunction

    function automatic logic is_interior(input logic [COORD_W-1:0] row,
                                         input logic [COORD_W-1:0] col);
        return (int'(row) > 0) && (int'(row) < ROWS - 1)
            && (int'(col) > 0) && (int'(col) < COLS - 1);
    endfunction

    function automatic logic [CELL_AW-1:0] cell_addr(input logic [COORD_W-1:0] row,
                                                     input logic [COORD_W-1:0] col);
        return CELL_AW'(row) * CELL_AW'(COLS) + CELL_AW'(col);
    endfunction

endpackage

// ===== sv/grid_maze_path_finder.sv =====
// Top level of the depth-first maze path finder: config registers, RAMs,
// walk sequencer and output register. Depends on gmp_pkg and all gmp_ modules.
//
// Channel   Direction  Handshake              Payload
// in        input      i_in_valid / o_in_stall  gmp_pkg::t_in
// out       output     o_out_valid / i_out_stall gmp_pkg::t_out
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A cell load is written straight into the maze map. A solve clears the visited
// map, checks the start, tries neighbors, rejects border steps, backtracks and
// sends out each path cell, waiting while the output is stalled.
// After reset a pass clears both cell maps; no item is taken then.
// Input is stalled while a solve runs; configuration writes are always taken.
module grid_maze_path_finder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  gmp_pkg::t_in                      i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output gmp_pkg::t_out                     o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gmp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gmp_pkg::COORD_W-1:0]       i_cfg_data
);

    gmp_pkg::t_cfg              r_cfg, n_cfg;
    gmp_pkg::t_bit_req          w_maze_req, w_vis_req;
    gmp_pkg::t_stk_req          w_stk_req;
    logic                       w_maze_rdata, w_vis_rdata;
    logic [gmp_pkg::STK_W-1:0]  w_stk_rdata;
    logic                       w_slot_free;
    gmp_pkg::t_emit             w_emit;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                gmp_pkg::REG_START_ROW: n_cfg.start_row = i_cfg_data;
                gmp_pkg::REG_START_COL: n_cfg.start_col = i_cfg_data;
                gmp_pkg::REG_END_ROW:   n_cfg.end_row   = i_cfg_data;
                gmp_pkg::REG_END_COL:   n_cfg.end_col   = i_cfg_data;
                default:                n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_row <= gmp_pkg::COORD_W'(1);
            r_cfg.start_col <= gmp_pkg::COORD_W'(1);
            r_cfg.end_row   <= gmp_pkg::COORD_W'(6);
            r_cfg.end_col   <= gmp_pkg::COORD_W'(6);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    gmp_ram #(
        .WIDTH (1),
        .DEPTH (gmp_pkg::CELLS)
    ) u_maze_ram (
        .i_clk   (i_clk),
        .i_we    (w_maze_req.we),
        .i_waddr (w_maze_req.waddr),
        .i_wdata (w_maze_req.wdata),
        .i_re    (w_maze_req.re),
        .i_raddr (w_maze_req.raddr),
        .o_rdata (w_maze_rdata)
    );

    gmp_ram #(
        .WIDTH (1),
        .DEPTH (gmp_pkg::CELLS)
    ) u_vis_ram (
        .i_clk   (i_clk),
        .i_we    (w_vis_req.we),
        .i_waddr (w_vis_req.waddr),
        .i_wdata (w_vis_req.wdata),
        .i_re    (w_vis_req.re),
        .i_raddr (w_vis_req.raddr),
        .o_rdata (w_vis_rdata)
    );

    gmp_ram #(
        .WIDTH (gmp_pkg::STK_W),
        .DEPTH (gmp_pkg::INTERIOR)
    ) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (w_stk_req.we),
        .i_waddr (w_stk_req.waddr),
        .i_wdata (w_stk_req.wdata),
        .i_re    (w_stk_req.re),
        .i_raddr (w_stk_req.raddr),
        .o_rdata (w_stk_rdata)
    );

    gmp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in         (i_in),
        .i_cfg        (r_cfg),
        .o_maze_req   (w_maze_req),
        .i_maze_rdata (w_maze_rdata),
        .o_vis_req    (w_vis_req),
        .i_vis_rdata  (w_vis_rdata),
        .o_stk_req    (w_stk_req),
        .i_stk_rdata  (gmp_pkg::t_stk_entry'(w_stk_rdata)),
        .i_slot_free  (w_slot_free),
        .o_emit       (w_emit)
    );

    gmp_outreg u_outreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_emit      (w_emit),
        .o_slot_free (w_slot_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

// ===== sv/gmp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module gmp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/gmp_ctrl.sv =====
// Walk sequencer: clears the maps, runs the depth-first walk over the RAMs
// and steps the path out. Depends on gmp_pkg and the shared macro header.
`include "grid_maze_path_finder_defines.svh"

module gmp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gmp_pkg::t_in        i_in,
    input  gmp_pkg::t_cfg       i_cfg,
    output gmp_pkg::t_bit_req   o_maze_req,
    input  logic                i_maze_rdata,
    output gmp_pkg::t_bit_req   o_vis_req,
    input  logic                i_vis_rdata,
    output gmp_pkg::t_stk_req   o_stk_req,
    input  gmp_pkg::t_stk_entry i_stk_rdata,
    input  logic                i_slot_free,
    output gmp_pkg::t_emit      o_emit
);

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_START   = 10'b0000000100,
        S_STCHK   = 10'b0000001000,
        S_CHECK   = 10'b0000010000,
        S_PROBE   = 10'b0000100000,
        S_POP     = 10'b0001000000,
        S_EMIT_RD = 10'b0010000000,
        S_EMIT_WR = 10'b0100000000,
        S_NF      = 10'b1000000000
    } t_state;

    t_state                                  r_state, n_state;
    logic                                    r_clr_maze, n_clr_maze;
    logic [gmp_pkg::CELL_AW-1:0]             r_clr_addr, n_clr_addr;
    gmp_pkg::t_stk_entry                     r_top, n_top;
    logic [gmp_pkg::DEPTH_W-1:0]             r_depth, n_depth;
    logic [gmp_pkg::DEPTH_W-1:0]             r_k, n_k;
    logic [gmp_pkg::COORD_W-1:0]             r_nbr_row, n_nbr_row;
    logic [gmp_pkg::COORD_W-1:0]             r_nbr_col, n_nbr_col;
    logic [gmp_pkg::COORD_W-1:0]             w_nrow, w_ncol;
    logic                                    w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_maze <= 1'b1;
            r_clr_addr <= '0;
            r_depth    <= '0;
            r_k        <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_maze <= n_clr_maze;
            r_clr_addr <= n_clr_addr;
            r_depth    <= n_depth;
            r_k        <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top     <= n_top;
        r_nbr_row <= n_nbr_row;
        r_nbr_col <= n_nbr_col;
    end

    always_comb begin
        w_nrow = r_top.row;
        w_ncol = r_top.col;
        case (r_top.dir)
            gmp_pkg::DIR_UP:    w_nrow = r_top.row - gmp_pkg::COORD_W'(1);
            gmp_pkg::DIR_DOWN:  w_nrow = r_top.row + gmp_pkg::COORD_W'(1);
            gmp_pkg::DIR_LEFT:  w_ncol = r_top.col - gmp_pkg::COORD_W'(1);
            gmp_pkg::DIR_RIGHT: w_ncol = r_top.col + gmp_pkg::COORD_W'(1);
            default: begin
                w_nrow = r_top.row;
                w_ncol = r_top.col;
            end
        endcase
    end

    assign w_push = i_maze_rdata && !i_vis_rdata;

    always_comb begin
        n_state    = r_state;
        n_clr_maze = r_clr_maze;
        n_clr_addr = r_clr_addr;
        n_top      = r_top;
        n_depth    = r_depth;
        n_k        = r_k;
        n_nbr_row  = r_nbr_row;
        n_nbr_col  = r_nbr_col;
        o_maze_req = '0;
        o_vis_req  = '0;
        o_stk_req  = '0;
        o_emit     = '0;
        o_in_stall = (r_state != S_IDLE);

        case (r_state)
            S_CLEAR: begin
                o_maze_req.we    = r_clr_maze;
                o_maze_req.waddr = r_clr_addr;
                o_vis_req.we     = 1'b1;
                o_vis_req.waddr  = r_clr_addr;
                if (r_clr_addr == gmp_pkg::CELL_AW'(gmp_pkg::CELLS - 1)) begin
                    n_clr_addr = '0;
                    n_clr_maze = 1'b0;
                    n_state    = r_clr_maze ? S_IDLE : S_START;
                end else begin
                    n_clr_addr = r_clr_addr + gmp_pkg::CELL_AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_in.mode) begin
                        o_maze_req.we    = gmp_pkg::in_grid(i_in.cell_row, i_in.cell_col);
                        o_maze_req.waddr = gmp_pkg::cell_addr(i_in.cell_row, i_in.cell_col);
                        o_maze_req.wdata = i_in.cell_open;
                    end else begin
                        n_state = S_CLEAR;
                    end
                end
            end
            S_START: begin
                o_maze_req.re    = 1'b1;
                o_maze_req.raddr = gmp_pkg::cell_addr(i_cfg.start_row, i_cfg.start_col);
                n_state          = S_STCHK;
            end
            S_STCHK: begin
                if (gmp_pkg::is_interior(i_cfg.start_row, i_cfg.start_col) && i_maze_rdata)
                begin
                    o_vis_req.we    = 1'b1;
                    o_vis_req.waddr = gmp_pkg::cell_addr(i_cfg.start_row, i_cfg.start_col);
                    o_vis_req.wdata = 1'b1;
                    n_top.row       = i_cfg.start_row;
                    n_top.col       = i_cfg.start_col;
                    n_top.dir       = gmp_pkg::DIR_UP;
                    n_depth         = gmp_pkg::DEPTH_W'(1);
                    n_state         = S_CHECK;
                end else begin
                    n_state = S_NF;
                end
            end
            S_CHECK: begin
                if (r_top.dir == gmp_pkg::DIR_UP && r_top.row == i_cfg.end_row
                    && r_top.col == i_cfg.end_col) begin
                    n_k     = '0;
                    n_state = S_EMIT_RD;
                end else if (r_top.dir < gmp_pkg::DIR_DONE) begin
                    n_top.dir = r_top.dir + gmp_pkg::DIR_W'(1);
                    if (gmp_pkg::is_interior(w_nrow, w_ncol)
                        && r_depth < gmp_pkg::DEPTH_W'(gmp_pkg::INTERIOR)) begin
                        o_maze_req.re    = 1'b1;
                        o_maze_req.raddr = gmp_pkg::cell_addr(w_nrow, w_ncol);
                        o_vis_req.re     = 1'b1;
                        o_vis_req.raddr  = gmp_pkg::cell_addr(w_nrow, w_ncol);
                        n_nbr_row        = w_nrow;
                        n_nbr_col        = w_ncol;
                        n_state          = S_PROBE;
                    end
                end else begin
                    n_depth = r_depth - gmp_pkg::DEPTH_W'(1);
                    if (r_depth == gmp_pkg::DEPTH_W'(1)) begin
                        n_state = S_NF;
                    end else begin
                        o_stk_req.re    = 1'b1;
                        o_stk_req.raddr = gmp_pkg::STK_AW'(r_depth - gmp_pkg::DEPTH_W'(2));
                        n_state         = S_POP;
                    end
                end
            end
            S_PROBE: begin
                if (w_push) begin
                    o_vis_req.we    = 1'b1;
                    o_vis_req.waddr = gmp_pkg::cell_addr(r_nbr_row, r_nbr_col);
                    o_vis_req.wdata = 1'b1;
                    o_stk_req.we    = 1'b1;
                    o_stk_req.waddr = gmp_pkg::STK_AW'(r_depth - gmp_pkg::DEPTH_W'(1));
                    o_stk_req.wdata = r_top;
                    n_top.row       = r_nbr_row;
                    n_top.col       = r_nbr_col;
                    n_top.dir       = gmp_pkg::DIR_UP;
                    n_depth         = r_depth + gmp_pkg::DEPTH_W'(1);
                end
                n_state = S_CHECK;
            end
            S_POP: begin
                n_top   = i_stk_rdata;
                n_state = S_CHECK;
            end
            S_EMIT_RD: begin
                if (r_k == r_depth - gmp_pkg::DEPTH_W'(1)) begin
                    if (i_slot_free) begin
                        o_emit.load          = 1'b1;
                        o_emit.data.path_row = r_top.row;
                        o_emit.data.path_col = r_top.col;
                        o_emit.data.found    = 1'b1;
                        o_emit.data.last     = 1'b1;
                        n_depth              = '0;
                        n_state              = S_IDLE;
                    end
                end else begin
                    o_stk_req.re    = 1'b1;
                    o_stk_req.raddr = gmp_pkg::STK_AW'(r_k);
                    n_state         = S_EMIT_WR;
                end
            end
            S_EMIT_WR: begin
                if (i_slot_free) begin
                    o_emit.load          = 1'b1;
                    o_emit.data.path_row = i_stk_rdata.row;
                    o_emit.data.path_col = i_stk_rdata.col;
                    o_emit.data.found    = 1'b1;
                    o_emit.data.last     = 1'b0;
                    n_k                  = r_k + gmp_pkg::DEPTH_W'(1);
                    n_state              = S_EMIT_RD;
                end
            end
            S_NF: begin
                if (i_slot_free) begin
                    o_emit.load = 1'b1;
                    o_emit.data = '0;
                    o_emit.data.last = 1'b1;
                    n_depth     = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `GMP_ASSERT(a_depth_bound, 1'b1, r_depth <= gmp_pkg::DEPTH_W'(gmp_pkg::INTERIOR), "Walk depth exceeds the interior size.")
    `GMP_ASSERT(a_check_nonempty, r_state == S_CHECK, r_depth != '0, "Walk step with an empty stack.")
    `GMP_ASSERT_NEXT(a_push_grows, r_state == S_PROBE && w_push, r_depth == $past(r_depth) + gmp_pkg::DEPTH_W'(1), "Push did not grow the stack.")
    `GMP_ASSERT(a_emit_slot, o_emit.load, i_slot_free, "Result loaded while the output register is occupied.")

endmodule

// ===== sv/gmp_outreg.sv =====
// Output register that holds one result until the downstream transfer.
// Depends on gmp_pkg.
module gmp_outreg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gmp_pkg::t_emit i_emit,
    output logic           o_slot_free,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output gmp_pkg::t_out  o_out
);

    logic          r_valid, n_valid;
    gmp_pkg::t_out r_data, n_data;

    assign o_slot_free = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_emit.load) begin
            n_valid = 1'b1;
            n_data  = i_emit.data;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_data;

endmodule
